// File: hw/rtl/closest_point_on_triangle_top_assert.svh
// Assertion helpers for the closest-point pipeline
`ifndef CLOSEST_POINT_ON_TRIANGLE_TOP_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_TOP_ASSERT_SVH

// same-cycle implication
`define CPT_CHK_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("cpt check failed");

// next-cycle implication
`define CPT_CHK_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("cpt check failed");

`endif

// File: hw/rtl/cpt_pkg.sv
package cpt_pkg;

  localparam int COORD_W   = 32;
  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT   = 3;

  typedef enum logic [2:0] {
    REG_A  = 3'd0,
    REG_B  = 3'd1,
    REG_AB = 3'd2,
    REG_C  = 3'd3,
    REG_AC = 3'd4,
    REG_BC = 3'd5,
    REG_IN = 3'd6
  } region_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic signed [COORD_W-1:0] near_z;
    logic [2:0]                region;
    logic                      degenerate;
  } out_item_t;

endpackage

// File: hw/rtl/cpt_mul.sv
module cpt_mul import cpt_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int XA = NA * MUL_CHUNK;
  localparam int XB = NB * MUL_CHUNK;
  localparam int PW = AW + BW;

  logic [AW-1:0]          am_nxt, am_r;
  logic [BW-1:0]          bm_nxt, bm_r;
  logic                   neg0_r, neg1_r;
  logic [2*MUL_CHUNK-1:0] pp_r [NA][NB];
  logic [XA-1:0]          ax;
  logic [XB-1:0]          bx;
  logic [PW-1:0]          sum;
  logic signed [PW-1:0]   p_r;

  // sign-magnitude split so the chunk products stay unsigned
  assign am_nxt = a[AW-1] ? AW'(~a + AW'(1)) : AW'(a);
  assign bm_nxt = b[BW-1] ? BW'(~b + BW'(1)) : BW'(b);
  assign ax = XA'(am_r);
  assign bx = XB'(bm_r);

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(pp_r[i][j]) << ((i + j) * MUL_CHUNK));
      end
    end
  end

  always_ff @(posedge clk) begin
    am_r   <= am_nxt;
    bm_r   <= bm_nxt;
    neg0_r <= a[AW-1] ^ b[BW-1];
    neg1_r <= neg0_r;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= ax[i*MUL_CHUNK +: MUL_CHUNK] * bx[j*MUL_CHUNK +: MUL_CHUNK];
      end
    end
    p_r <= $signed(neg1_r ? PW'(~sum + PW'(1)) : sum);
  end

  assign p = p_r;

endmodule

// File: hw/rtl/cpt_div.sv
module cpt_div import cpt_pkg::*; #(
  parameter int NW = 171,
  parameter int DW = 139,
  parameter int QW = 34,
  parameter int TW = 37
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [NW-1:0] in_num,
  input  logic signed [DW-1:0] in_den,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_vld,
  output logic [QW:0]          out_q,
  output logic                 out_neg,
  output logic                 out_ovf,
  output logic [TW-1:0]        out_tag
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0]   nm;
  logic [DW-1:0]   dm;
  logic [CW-1:0]   rem_r [0:QW];
  logic [CW-1:0]   rem_nxt [0:QW];
  logic [QW-1:0]   q_r [0:QW];
  logic [QW-1:0]   q_nxt [0:QW];
  logic [DW-1:0]   dm_r [0:QW];
  logic            neg_r [0:QW];
  logic            ovf_r [0:QW];
  logic [TW-1:0]   tag_r [0:QW];
  logic [QW:0]     vld_r;
  logic            rnd;
  logic            out_vld_r, out_neg_r, out_ovf_r;
  logic [QW:0]     out_q_r;
  logic [TW-1:0]   out_tag_r;

  assign nm = in_num[NW-1] ? NW'(~in_num + NW'(1)) : NW'(in_num);
  assign dm = in_den[DW-1] ? DW'(~in_den + DW'(1)) : DW'(in_den);

  // one quotient bit per stage, most significant first
  always_comb begin
    rem_nxt[0] = rem_r[0];
    q_nxt[0]   = q_r[0];
    for (int s = 1; s <= QW; s++) begin
      if (rem_r[s-1] >= (CW'(dm_r[s-1]) << (QW - s))) begin
        rem_nxt[s] = rem_r[s-1] - (CW'(dm_r[s-1]) << (QW - s));
        q_nxt[s]   = q_r[s-1] | (QW'(1) << (QW - s));
      end else begin
        rem_nxt[s] = rem_r[s-1];
        q_nxt[s]   = q_r[s-1];
      end
    end
  end

  assign rnd = {rem_r[QW], 1'b0} >= {1'b0, CW'(dm_r[QW])};

  always_ff @(posedge clk) begin
    rem_r[0] <= CW'(nm);
    q_r[0]   <= '0;
    dm_r[0]  <= dm;
    neg_r[0] <= in_num[NW-1] ^ in_den[DW-1];
    ovf_r[0] <= CW'(nm) >= (CW'(dm) << QW);
    tag_r[0] <= in_tag;
    for (int s = 1; s <= QW; s++) begin
      rem_r[s] <= rem_nxt[s];
      q_r[s]   <= q_nxt[s];
      dm_r[s]  <= dm_r[s-1];
      neg_r[s] <= neg_r[s-1];
      ovf_r[s] <= ovf_r[s-1];
      tag_r[s] <= tag_r[s-1];
    end
    out_q_r   <= (QW+1)'(q_r[QW]) + (QW+1)'(rnd);
    out_neg_r <= neg_r[QW];
    out_ovf_r <= ovf_r[QW];
    out_tag_r <= tag_r[QW];
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[QW-1:0], in_vld};
      out_vld_r <= vld_r[QW];
    end
  end

  assign out_vld = out_vld_r;
  assign out_q   = out_q_r;
  assign out_neg = out_neg_r;
  assign out_ovf = out_ovf_r;
  assign out_tag = out_tag_r;

endmodule

// File: hw/rtl/closest_point_on_triangle_top.sv
// Channel   Ports                      Handshake
// input     start, busy, in_data       taken when start high and busy low
// result    out_strobe, out_data       one cycle per item, no back-pressure
//
// Fully pipelined: one item per cycle, busy is always low.
// The bit-per-stage divider (one per axis) makes up most of the path from
// accept to strobe with 32-bit coordinates.
// Synchronous active-low reset clears only the valid bits; nothing stalls.
`include "closest_point_on_triangle_top_assert.svh"

module closest_point_on_triangle_top import cpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);

  localparam int W    = COORD_W;
  localparam int DIFW = W + 1;
  localparam int DOTP = 2 * DIFW;
  localparam int DOTW = DOTP + 2;
  localparam int VP   = 2 * DOTW;
  localparam int VW   = VP + 1;
  localparam int DENW = VW + 2;
  localparam int NP   = DIFW + VW;
  localparam int NW   = NP + 1;
  localparam int QW   = W + 2;
  localparam int TW   = 3 + 1 + 1 + W;
  localparam int SUMW = QW + 3;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [2:0][W-1:0]    a;
    logic [2:0][W-1:0]    b;
    logic [2:0][W-1:0]    c;
    logic [2:0][DIFW-1:0] ab;
    logic [2:0][DIFW-1:0] ac;
    logic [2:0][DIFW-1:0] bc;
  } sd_t;

  typedef struct packed {
    sd_t                  sd;
    logic [5:0][DOTW-1:0] d;
  } sd2_t;

  typedef struct packed {
    region_t           region;
    logic              degen;
    logic              direct;
    logic [2:0][W-1:0] st;
    logic [DENW-1:0]   den;
  } sel_t;

  // stage 0: input register
  in_item_t in_r;
  logic     v0_r;

  // stage 1: differences
  sd_t                    sd1_r;
  logic signed [DIFW-1:0] ap1_r [3];
  logic signed [DIFW-1:0] bp1_r [3];
  logic signed [DIFW-1:0] cp1_r [3];
  logic                   v1_r;
  logic signed [W-1:0]    pi [3];
  logic signed [W-1:0]    ai [3];
  logic signed [W-1:0]    bi [3];
  logic signed [W-1:0]    ci [3];

  // dot products
  logic signed [DIFW-1:0] dl_a [6][3];
  logic signed [DIFW-1:0] dl_b [6][3];
  logic signed [DOTP-1:0] dp [6][3];
  sd_t                    dly1_r [MUL_LAT];
  logic [MUL_LAT-1:0]     vd1_r;

  // stage 2
  sd2_t                   s2_r;
  logic                   v2_r;
  logic signed [DOTW-1:0] vm_a [6];
  logic signed [DOTW-1:0] vm_b [6];
  logic signed [VP-1:0]   vp [6];
  sd2_t                   dly2_r [MUL_LAT];
  logic [MUL_LAT-1:0]     vd2_r;

  // stage 3
  sd2_t                     s3_r;
  logic signed [VW-1:0]     va3_r, vb3_r, vc3_r;
  logic signed [DOTW:0]     e3_r, f3_r;
  logic                     v3_r;

  // stage 4: region choice
  sel_t                   sel_nxt, sel4_r;
  logic signed [DIFW-1:0] da_nxt [3];
  logic signed [DIFW-1:0] db_nxt [3];
  logic signed [DIFW-1:0] da4_r [3];
  logic signed [DIFW-1:0] db4_r [3];
  logic signed [VW-1:0]   s1_nxt, s2_nxt, s1_4_r, s2_4_r;
  logic                   v4_r;
  logic signed [DOTW-1:0] d1, d2, d3, d4, d5, d6;
  logic signed [DENW-1:0] eden;
  logic signed [NP-1:0]   pa [3];
  logic signed [NP-1:0]   pb [3];
  sel_t                   dly4_r [MUL_LAT];
  logic [MUL_LAT-1:0]     vd4_r;

  // stage 5: numerators
  logic signed [NW-1:0] num5_r [3];
  sel_t                 sel5_r;
  logic                 v5_r;

  // dividers
  logic          dv [3];
  logic [QW:0]   dq [3];
  logic          dneg [3];
  logic          dovf [3];
  logic [TW-1:0] dtag [3];

  out_item_t out_nxt, out_r;
  logic      strobe_r;
  logic signed [W-1:0] near [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_comb begin
    pi[0] = in_r.point_x; pi[1] = in_r.point_y; pi[2] = in_r.point_z;
    ai[0] = in_r.a_x;     ai[1] = in_r.a_y;     ai[2] = in_r.a_z;
    bi[0] = in_r.b_x;     bi[1] = in_r.b_y;     bi[2] = in_r.b_z;
    ci[0] = in_r.c_x;     ci[1] = in_r.c_y;     ci[2] = in_r.c_z;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sd1_r.a[k]  <= ai[k];
      sd1_r.b[k]  <= bi[k];
      sd1_r.c[k]  <= ci[k];
      sd1_r.ab[k] <= DIFW'(bi[k]) - DIFW'(ai[k]);
      sd1_r.ac[k] <= DIFW'(ci[k]) - DIFW'(ai[k]);
      sd1_r.bc[k] <= DIFW'(ci[k]) - DIFW'(bi[k]);
      ap1_r[k]    <= DIFW'(pi[k]) - DIFW'(ai[k]);
      bp1_r[k]    <= DIFW'(pi[k]) - DIFW'(bi[k]);
      cp1_r[k]    <= DIFW'(pi[k]) - DIFW'(ci[k]);
    end
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  // d1 = ab.ap, d2 = ac.ap, d3 = ab.bp, d4 = ac.bp, d5 = ab.cp, d6 = ac.cp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dl_a[0][k] = $signed(sd1_r.ab[k]); dl_b[0][k] = ap1_r[k];
      dl_a[1][k] = $signed(sd1_r.ac[k]); dl_b[1][k] = ap1_r[k];
      dl_a[2][k] = $signed(sd1_r.ab[k]); dl_b[2][k] = bp1_r[k];
      dl_a[3][k] = $signed(sd1_r.ac[k]); dl_b[3][k] = bp1_r[k];
      dl_a[4][k] = $signed(sd1_r.ab[k]); dl_b[4][k] = cp1_r[k];
      dl_a[5][k] = $signed(sd1_r.ac[k]); dl_b[5][k] = cp1_r[k];
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_ax
      cpt_mul #(.AW(DIFW), .BW(DIFW)) u_mul (
        .clk (clk),
        .a   (dl_a[j][k]),
        .b   (dl_b[j][k]),
        .p   (dp[j][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    dly1_r[0] <= sd1_r;
    for (int i = 1; i < MUL_LAT; i++) begin
      dly1_r[i] <= dly1_r[i-1];
    end
    s2_r.sd <= dly1_r[MUL_LAT-1];
    for (int j = 0; j < 6; j++) begin
      s2_r.d[j] <= DOTW'(dp[j][0]) + DOTW'(dp[j][1]) + DOTW'(dp[j][2]);
    end
    if (!rst_n) begin
      vd1_r <= '0;
      v2_r  <= 1'b0;
    end else begin
      vd1_r <= {vd1_r[MUL_LAT-2:0], v1_r};
      v2_r  <= vd1_r[MUL_LAT-1];
    end
  end

  // vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
  always_comb begin
    vm_a[0] = $signed(s2_r.d[0]); vm_b[0] = $signed(s2_r.d[3]);
    vm_a[1] = $signed(s2_r.d[2]); vm_b[1] = $signed(s2_r.d[1]);
    vm_a[2] = $signed(s2_r.d[4]); vm_b[2] = $signed(s2_r.d[1]);
    vm_a[3] = $signed(s2_r.d[0]); vm_b[3] = $signed(s2_r.d[5]);
    vm_a[4] = $signed(s2_r.d[2]); vm_b[4] = $signed(s2_r.d[5]);
    vm_a[5] = $signed(s2_r.d[4]); vm_b[5] = $signed(s2_r.d[3]);
  end

  for (genvar j = 0; j < 6; j++) begin : g_bary
    cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul (
      .clk (clk),
      .a   (vm_a[j]),
      .b   (vm_b[j]),
      .p   (vp[j])
    );
  end

  always_ff @(posedge clk) begin
    dly2_r[0] <= s2_r;
    for (int i = 1; i < MUL_LAT; i++) begin
      dly2_r[i] <= dly2_r[i-1];
    end
    s3_r  <= dly2_r[MUL_LAT-1];
    vc3_r <= VW'(vp[0]) - VW'(vp[1]);
    vb3_r <= VW'(vp[2]) - VW'(vp[3]);
    va3_r <= VW'(vp[4]) - VW'(vp[5]);
    e3_r  <= (DOTW+1)'($signed(dly2_r[MUL_LAT-1].d[3]))
           - (DOTW+1)'($signed(dly2_r[MUL_LAT-1].d[2]));
    f3_r  <= (DOTW+1)'($signed(dly2_r[MUL_LAT-1].d[4]))
           - (DOTW+1)'($signed(dly2_r[MUL_LAT-1].d[5]));
    if (!rst_n) begin
      vd2_r <= '0;
      v3_r  <= 1'b0;
    end else begin
      vd2_r <= {vd2_r[MUL_LAT-2:0], v2_r};
      v3_r  <= vd2_r[MUL_LAT-1];
    end
  end

  assign d1 = $signed(s3_r.d[0]);
  assign d2 = $signed(s3_r.d[1]);
  assign d3 = $signed(s3_r.d[2]);
  assign d4 = $signed(s3_r.d[3]);
  assign d5 = $signed(s3_r.d[4]);
  assign d6 = $signed(s3_r.d[5]);

  // Voronoi tests in fixed order; every vertex case, and any edge or
  // interior case with a zero denominator, bypass the divider
  always_comb begin
    sel_nxt.region = REG_IN;
    sel_nxt.degen  = 1'b0;
    sel_nxt.direct = 1'b0;
    sel_nxt.st     = s3_r.sd.a;
    s1_nxt         = '0;
    s2_nxt         = '0;
    eden           = '0;
    for (int k = 0; k < 3; k++) begin
      da_nxt[k] = $signed(s3_r.sd.ab[k]);
      db_nxt[k] = '0;
    end
    priority if (d1 <= 0 && d2 <= 0) begin
      sel_nxt.region = REG_A;
      sel_nxt.direct = 1'b1;
    end else if (d3 >= 0 && e3_r <= 0) begin
      sel_nxt.region = REG_B;
      sel_nxt.direct = 1'b1;
      sel_nxt.st     = s3_r.sd.b;
    end else if (vc3_r <= 0 && d1 >= 0 && d3 <= 0) begin
      sel_nxt.region = REG_AB;
      s1_nxt         = VW'(d1);
      eden           = DENW'(d1) - DENW'(d3);
    end else if (d6 >= 0 && f3_r <= 0) begin
      sel_nxt.region = REG_C;
      sel_nxt.direct = 1'b1;
      sel_nxt.st     = s3_r.sd.c;
    end else if (vb3_r <= 0 && d2 >= 0 && d6 <= 0) begin
      sel_nxt.region = REG_AC;
      s1_nxt         = VW'(d2);
      eden           = DENW'(d2) - DENW'(d6);
      for (int k = 0; k < 3; k++) begin
        da_nxt[k] = $signed(s3_r.sd.ac[k]);
      end
    end else if (va3_r <= 0 && e3_r >= 0 && f3_r >= 0) begin
      sel_nxt.region = REG_BC;
      sel_nxt.st     = s3_r.sd.b;
      s1_nxt         = VW'(e3_r);
      eden           = DENW'(e3_r) + DENW'(f3_r);
      for (int k = 0; k < 3; k++) begin
        da_nxt[k] = $signed(s3_r.sd.bc[k]);
      end
    end else begin
      s1_nxt = vb3_r;
      s2_nxt = vc3_r;
      eden   = DENW'(va3_r) + DENW'(vb3_r) + DENW'(vc3_r);
      for (int k = 0; k < 3; k++) begin
        db_nxt[k] = $signed(s3_r.sd.ac[k]);
      end
      sel_nxt.degen = (eden == 0);
    end
    if (eden == 0) begin
      sel_nxt.direct = 1'b1;
    end
    // keep the divider clear of a zero divisor on bypassed items
    sel_nxt.den = sel_nxt.direct ? DENW'(1) : eden;
    if (sel_nxt.direct) begin
      s1_nxt = '0;
      s2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    sel4_r <= sel_nxt;
    s1_4_r <= s1_nxt;
    s2_4_r <= s2_nxt;
    for (int k = 0; k < 3; k++) begin
      da4_r[k] <= da_nxt[k];
      db4_r[k] <= db_nxt[k];
    end
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_num
    cpt_mul #(.AW(DIFW), .BW(VW)) u_mul_a (
      .clk (clk),
      .a   (da4_r[k]),
      .b   (s1_4_r),
      .p   (pa[k])
    );
    cpt_mul #(.AW(DIFW), .BW(VW)) u_mul_b (
      .clk (clk),
      .a   (db4_r[k]),
      .b   (s2_4_r),
      .p   (pb[k])
    );
  end

  always_ff @(posedge clk) begin
    dly4_r[0] <= sel4_r;
    for (int i = 1; i < MUL_LAT; i++) begin
      dly4_r[i] <= dly4_r[i-1];
    end
    sel5_r <= dly4_r[MUL_LAT-1];
    for (int k = 0; k < 3; k++) begin
      num5_r[k] <= NW'(pa[k]) + NW'(pb[k]);
    end
    if (!rst_n) begin
      vd4_r <= '0;
      v5_r  <= 1'b0;
    end else begin
      vd4_r <= {vd4_r[MUL_LAT-2:0], v4_r};
      v5_r  <= vd4_r[MUL_LAT-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpt_div #(.NW(NW), .DW(DENW), .QW(QW), .TW(TW)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (v5_r),
      .in_num  (num5_r[k]),
      .in_den  ($signed(sel5_r.den)),
      .in_tag  ({sel5_r.region, sel5_r.degen, sel5_r.direct, sel5_r.st[k]}),
      .out_vld (dv[k]),
      .out_q   (dq[k]),
      .out_neg (dneg[k]),
      .out_ovf (dovf[k]),
      .out_tag (dtag[k])
    );
  end

  // start + signed quotient, saturated to the coordinate range; bypassed items take the start
  always_comb begin
    logic signed [W-1:0]    st;
    logic signed [SUMW-1:0] qs;
    logic signed [SUMW-1:0] sum;
    for (int k = 0; k < 3; k++) begin
      st  = $signed(dtag[k][W-1:0]);
      qs  = dneg[k] ? -$signed(SUMW'(dq[k])) : $signed(SUMW'(dq[k]));
      sum = SUMW'(st) + qs;
      if (dtag[k][W]) begin
        near[k] = st;
      end else if (dovf[k]) begin
        near[k] = dneg[k] ? CMIN : CMAX;
      end else if (sum > SUMW'(CMAX)) begin
        near[k] = CMAX;
      end else if (sum < SUMW'(CMIN)) begin
        near[k] = CMIN;
      end else begin
        near[k] = sum[W-1:0];
      end
    end
    out_nxt.near_x     = near[0];
    out_nxt.near_y     = near[1];
    out_nxt.near_z     = near[2];
    out_nxt.region     = dtag[0][TW-1 -: 3];
    out_nxt.degenerate = dtag[0][W+1];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv[0];
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  `CPT_CHK_NEXT(a_accept, clk, rst_n, start && !busy, v0_r)
  `CPT_CHK_NEXT(a_deliver, clk, rst_n, dv[0], out_strobe)
  `CPT_CHK_NOW(a_lanes, clk, rst_n, dv[0], dv[1] && dv[2])
  `CPT_CHK_NOW(a_degen, clk, rst_n, out_strobe && out_data.degenerate, out_data.region == REG_IN)

endmodule

// File: tb/tb_closest_point_on_triangle_top.sv
`timescale 1ns / 1ps

module tb_closest_point_on_triangle_top import cpt_pkg::*; ();

  typedef logic signed [255:0] wide_t;

  localparam int N_RANDOM  = 730;
  localparam int DRAIN_AT  = 400;
  localparam int TAIL_WAIT = 80;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_strobe;
  out_item_t out_data;

  in_item_t  query_q[$];
  out_item_t nearest_q[$];
  int        n_taken;
  int        n_bad;
  logic      drained;
  logic      all_queued;

  closest_point_on_triangle_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // round to nearest, ties away from zero
  function automatic wide_t div_round(wide_t num, wide_t den);
    wide_t n_abs;
    wide_t d_abs;
    wide_t q;
    wide_t r;
    n_abs = num < 0 ? -num : num;
    d_abs = den < 0 ? -den : den;
    q = n_abs / d_abs;
    r = n_abs % d_abs;
    if ((r <<< 1) >= d_abs) q = q + 1;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (COORD_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (COORD_W - 1));
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  function automatic out_item_t predict_nearest(in_item_t q);
    wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], r[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, num, den;
    region_t rg;
    logic dg;
    out_item_t o;
    p[0] = q.point_x; p[1] = q.point_y; p[2] = q.point_z;
    a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
    b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
    c[0] = q.c_x; c[1] = q.c_y; c[2] = q.c_z;
    d1 = 0; d2 = 0; d3 = 0; d4 = 0; d5 = 0; d6 = 0;
    for (int k = 0; k < 3; k++) begin
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
      bc[k] = c[k] - b[k];
      d1 += ab[k] * (p[k] - a[k]);
      d2 += ac[k] * (p[k] - a[k]);
      d3 += ab[k] * (p[k] - b[k]);
      d4 += ac[k] * (p[k] - b[k]);
      d5 += ab[k] * (p[k] - c[k]);
      d6 += ac[k] * (p[k] - c[k]);
    end
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    dg = 1'b0;
    num = 0;
    den = 0;
    if (d1 <= 0 && d2 <= 0) begin
      rg = REG_A; r = a;
    end else if (d3 >= 0 && d4 - d3 <= 0) begin
      rg = REG_B; r = b;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      rg = REG_AB; num = d1; den = d1 - d3;
      for (int k = 0; k < 3; k++)
        r[k] = den == 0 ? a[k] : a[k] + div_round(ab[k] * num, den);
    end else if (d6 >= 0 && d5 - d6 <= 0) begin
      rg = REG_C; r = c;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      rg = REG_AC; num = d2; den = d2 - d6;
      for (int k = 0; k < 3; k++)
        r[k] = den == 0 ? a[k] : a[k] + div_round(ac[k] * num, den);
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      rg = REG_BC; num = d4 - d3; den = num + (d5 - d6);
      for (int k = 0; k < 3; k++)
        r[k] = den == 0 ? b[k] : b[k] + div_round(bc[k] * num, den);
    end else begin
      rg = REG_IN;
      den = va + vb + vc;
      if (den == 0) begin
        dg = 1'b1; r = a;
      end else begin
        for (int k = 0; k < 3; k++)
          r[k] = a[k] + div_round(ab[k] * vb + ac[k] * vc, den);
      end
    end
    o.near_x = clamp_coord(r[0]);
    o.near_y = clamp_coord(r[1]);
    o.near_z = clamp_coord(r[2]);
    o.region = rg;
    o.degenerate = dg;
    return o;
  endfunction

  function automatic logic [COORD_W-1:0] near_val(int range_bits);
    logic [COORD_W-1:0] v;
    v = $urandom;
    if (range_bits >= COORD_W) return v;
    v = v & ((32'd1 << range_bits) - 1);
    return $signed(v) - $signed(32'd1 << (range_bits - 1));
  endfunction

  // flavour: 0 full range, 1 small triangle, 2 collinear, 3 coincident corners
  function automatic in_item_t random_query(int flavour);
    in_item_t q;
    int sz;
    int m;
    sz = $urandom_range(4, 30);
    q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (flavour != 0) begin
      q.point_x = near_val(sz + 1); q.point_y = near_val(sz + 1);
      q.point_z = near_val(sz + 1);
      q.a_x = near_val(sz); q.a_y = near_val(sz); q.a_z = near_val(sz);
      q.b_x = near_val(sz); q.b_y = near_val(sz); q.b_z = near_val(sz);
      q.c_x = near_val(sz); q.c_y = near_val(sz); q.c_z = near_val(sz);
      if ($urandom_range(0, 3) == 0) begin
        q.a_z = 0; q.b_z = 0; q.c_z = 0;
      end
    end
    if (flavour == 2) begin
      m = $urandom_range(0, 4) - 2;
      q.c_x = q.a_x + m * (q.b_x - q.a_x);
      q.c_y = q.a_y + m * (q.b_y - q.a_y);
      q.c_z = q.a_z + m * (q.b_z - q.a_z);
    end else if (flavour == 3) begin
      case ($urandom_range(0, 3))
        0: begin q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z; end
        1: begin q.c_x = q.a_x; q.c_y = q.a_y; q.c_z = q.a_z; end
        2: begin q.c_x = q.b_x; q.c_y = q.b_y; q.c_z = q.b_z; end
        default: begin
          q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z;
          q.c_x = q.a_x; q.c_y = q.a_y; q.c_z = q.a_z;
        end
      endcase
    end
    return q;
  endfunction

  function automatic in_item_t unit_tri(int px, int py, int pz);
    in_item_t q;
    q = '0;
    q.b_x = 32'sh10000;
    q.c_y = 32'sh10000;
    q.point_x = px; q.point_y = py; q.point_z = pz;
    return q;
  endfunction

  initial begin
    in_item_t q;
    int flav;
    all_queued = 1'b0;
    // every region on a unit triangle
    query_q.push_back(unit_tri(-32'sh10000, -32'sh10000, 0));
    query_q.push_back(unit_tri(32'sh20000, -32'sh8000, 0));
    query_q.push_back(unit_tri(32'sh8000, -32'sh10000, 32'sh1234));
    query_q.push_back(unit_tri(-32'sh8000, 32'sh20000, 0));
    query_q.push_back(unit_tri(-32'sh10000, 32'sh8000, 0));
    query_q.push_back(unit_tri(32'sh10000, 32'sh10000, -32'sh10000));
    query_q.push_back(unit_tri(32'sh4000, 32'sh4000, 32'sh10000));
    query_q.push_back(unit_tri(32'sh5555, 32'sh2aaa, 0));
    // short edge of length two, point off its midpoint
    q = unit_tri(1, -5, 0); q.b_x = 2; query_q.push_back(q);
    // extremes and saturation
    q = '0; query_q.push_back(q);
    q = '1; query_q.push_back(q);
    q = {12{32'h7fffffff}}; query_q.push_back(q);
    q = {12{32'h80000000}}; query_q.push_back(q);
    q = {32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         32'h80000000, 32'h80000000, 32'h80000000,
         32'h7fffffff, 32'h80000000, 32'h7fffffff,
         32'h80000000, 32'h7fffffff, 32'h7fffffff};
    query_q.push_back(q);
    q = {32'h80000000, 32'h7fffffff, 32'h0,
         32'h7fffffff, 32'h80000000, 32'h0,
         32'h80000000, 32'h80000000, 32'h0,
         32'h7fffffff, 32'h7fffffff, 32'h0};
    query_q.push_back(q);
    // collinear corners, one with a zero edge denominator
    q = unit_tri(32'sh8000, 32'sh8000, 0); q.c_y = 0; q.c_x = 32'sh20000;
    query_q.push_back(q);
    q = unit_tri(-32'sh8000, 32'sh8000, 0); q.c_y = 0; q.c_x = -32'sh10000;
    query_q.push_back(q);
    q = unit_tri(32'sh8000, 32'sh8000, 0); q.b_x = 0;
    query_q.push_back(q);
    q = unit_tri(32'sh8000, 32'sh8000, 0); q.c_y = 0; q.c_x = 32'sh10000;
    query_q.push_back(q);
    q = unit_tri(32'sh1000, 32'sh1000, 0); q.b_x = 0; q.c_y = 0;
    query_q.push_back(q);
    for (int i = 0; i < N_RANDOM; i++) begin
      flav = $urandom_range(0, 9);
      flav = flav < 2 ? 0 : flav < 7 ? 1 : flav < 9 ? 2 : 3;
      query_q.push_back(random_query(flav));
    end
    all_queued = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    int idle_pct;
    logic hold;
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
      n_taken <= 0;
      drained <= 1'b0;
    end else begin
      hold = 1'b0;
      if (start && !busy) begin
        nearest_q.push_back(predict_nearest(in_data));
        n_taken <= n_taken + 1;
        if (n_taken + 1 == DRAIN_AT) hold = 1'b1;
      end
      // one pause until the pipeline has emptied
      if (n_taken == DRAIN_AT && !drained) begin
        if (nearest_q.size() == 0) drained <= 1'b1;
        else hold = 1'b1;
      end
      idle_pct = n_taken < 250 ? 16 : n_taken < 500 ? 52 : 0;
      if (start && busy) begin
        start <= 1'b1;
      end else if (!hold && query_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data <= query_q.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (nearest_q.size() == 0) begin
        n_bad <= n_bad + 1;
        if (n_bad < 10) $display("unexpected result %h", out_data);
      end else begin
        want = nearest_q.pop_front();
        if (out_data.near_x !== want.near_x || out_data.near_y !== want.near_y ||
            out_data.near_z !== want.near_z || out_data.region !== want.region ||
            out_data.degenerate !== want.degenerate) begin
          n_bad <= n_bad + 1;
          if (n_bad < 10)
            $display("mismatch: want %h %h %h r%0d d%0d got %h %h %h r%0d d%0d",
                     want.near_x, want.near_y, want.near_z, want.region,
                     want.degenerate, out_data.near_x, out_data.near_y,
                     out_data.near_z, out_data.region, out_data.degenerate);
        end
      end
    end
  end

  initial begin
    n_bad = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (all_queued && query_q.size() == 0 && !start);
    wait (nearest_q.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_bad == 0 && nearest_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 100000);
    $display("FAIL");
    $finish;
  end

endmodule

// File: closest_point_on_triangle_top.f
+incdir+hw/rtl
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_mul.sv
hw/rtl/cpt_div.sv
hw/rtl/closest_point_on_triangle_top.sv
tb/tb_closest_point_on_triangle_top.sv
